// ===== hw/rtl/swm_pkg.sv =====
// Shared types for the sliding window maximum block.
package swm_pkg;

  // How far the cell row moves toward the front in one item.
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_ONE  = 2'd1,
    SHIFT_TWO  = 2'd2
  } swm_shift_t;

  // Per-item control broadcast to every cell.
  typedef struct packed {
    logic       update;
    logic       first;
    swm_shift_t shift;
  } swm_ctl_t;

endpackage

// ===== hw/rtl/swm_in_if.sv =====
// Input item channel: one sample and its first flag.
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           first;

  modport source (output valid, output sample, output first, input ready);
  modport sink (input valid, input sample, input first, output ready);
endinterface

// ===== hw/rtl/swm_out_if.sv =====
// Result item channel: one window maximum.
interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink (input valid, input window_max, output ready);
endinterface

// ===== hw/rtl/swm_cfg_if.sv =====
// Configuration write channel for the window length register.
interface swm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

// ===== hw/rtl/sliding_window_maximum_top.sv =====
// Sliding window maximum filter: top level with the deque cell row and the history RAM.
//
//   channel  modport  payload                      item accepted when
//   feed     sink     sample[SW], first            feed.valid && feed.ready
//   result   source   window_max[SW]               result.valid && result.ready
//   setup    sink     window_len[7]                setup.valid && setup.ready
//
// One sample per clock while feed.ready is high. The deque is a row of WINDOW_MAX cells
// that trim and append in the same cycle; the sliding-out sample comes from the history
// RAM, whose read is registered and launched ahead of the item, so the cycle after reset
// or a window_len write takes no item. Reset is synchronous and clears all control state;
// history and cell values are not cleared. A stalled result holds in the output
// register; feed stays ready while the waiting result is taken in the same cycle.
module sliding_window_maximum_top
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic             clk,
  input logic             rst,
  swm_in_if.sink          feed,
  swm_out_if.source       result,
  swm_cfg_if.sink         setup
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;  // ring index
  localparam int LW = $clog2(WINDOW_MAX + 1);                      // holds 0..WINDOW_MAX
  localparam int CW = (LW > 7) ? LW : 7;                           // length compare width
  localparam int SW = SAMPLE_WIDTH;

  // Registers.
  logic [6:0]          window_len;
  logic [AW-1:0]       wp;
  logic [LW-1:0]       fill;
  logic                settle;     // RAM read address not yet current
  logic                byp_valid;  // oldest sample was written in the previous item
  logic signed [SW-1:0] byp_data;
  logic                out_valid;
  logic signed [SW-1:0] out_data;

  // Item datapath.
  logic                 acc;
  logic signed [SW-1:0] x;
  logic [CW-1:0]        wl_ext;
  logic [LW-1:0]        len;
  logic [AW-1:0]        cur;
  logic [AW-1:0]        wp_next;
  logic [AW-1:0]        ptr_ahead;
  logic [AW:0]          rd_sum;
  logic [AW-1:0]        rd_addr;
  logic [LW-1:0]        fill_base;
  logic [LW-1:0]        fill_next;
  logic                 emit;
  logic [SW-1:0]        rd_data;
  logic signed [SW-1:0] oldest_val;
  logic                 full;
  logic [SW:0]          front;
  logic                 pop;
  swm_ctl_t             ctl;

  logic [SW:0]          post [WINDOW_MAX+2];
  logic                 kept [WINDOW_MAX];

  assign x   = feed.sample;
  assign acc = feed.valid && feed.ready;

  assign feed.ready  = !settle && (!out_valid || result.ready);
  assign setup.ready = 1'b1;

  assign result.valid      = out_valid;
  assign result.window_max = out_data;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    wl_ext = CW'(window_len);
    if (wl_ext == '0) begin
      len = LW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = LW'(wl_ext);
    end
  end

  // History write slot and fill level for this item.
  assign cur       = feed.first ? '0 : wp;
  assign wp_next   = (cur == AW'(WINDOW_MAX - 1)) ? '0 : cur + AW'(1);
  assign fill_base = feed.first ? '0 : fill;
  assign fill_next = (fill_base == LW'(WINDOW_MAX)) ? fill_base : fill_base + LW'(1);
  assign emit      = (fill_next >= len);

  // Read address for the next item's sliding-out sample: ptr - (len - 1), modulo the ring.
  assign ptr_ahead = acc ? wp_next : wp;
  assign rd_sum    = {1'b0, ptr_ahead} + (AW+1)'(WINDOW_MAX) - ((AW+1)'(len) - (AW+1)'(1));
  assign rd_addr   = (rd_sum >= (AW+1)'(WINDOW_MAX)) ?
                     AW'(rd_sum - (AW+1)'(WINDOW_MAX)) : AW'(rd_sum);

  swm_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW_MAX)
  ) u_history (
    .clk   (clk),
    .we    (acc),
    .waddr (cur),
    .wdata (x),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // A window of one slides out the sample just taken.
  always_comb begin
    if (len == LW'(1)) begin
      oldest_val = x;
    end else if (byp_valid) begin
      oldest_val = byp_data;
    end else begin
      oldest_val = $signed(rd_data);
    end
  end

  // Cell row: cell 0 is the deque front. Two virtual slots past the end carry the
  // appended sample when the row is full, and an empty entry.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic left_kept;
    if (i == 0) begin : g_head
      assign left_kept = 1'b1;
    end else begin : g_body
      assign left_kept = kept[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .x         (x),
      .left_kept (left_kept),
      .near_post (post[i+1]),
      .far_post  (post[i+2]),
      .kept      (kept[i]),
      .post      (post[i])
    );
  end

  assign full                 = kept[WINDOW_MAX-1];
  assign post[WINDOW_MAX]     = {full, x};
  assign post[WINDOW_MAX + 1] = {1'b0, x};

  // Full row drops its front before the append, so the front moves down one.
  assign front = full ? post[1] : post[0];
  assign pop   = emit && ($signed(front[SW-1:0]) == oldest_val);

  always_comb begin
    ctl.update = acc;
    ctl.first  = feed.first;
    case ({full, pop})
      2'b00:   ctl.shift = SHIFT_NONE;
      2'b11:   ctl.shift = SHIFT_TWO;
      default: ctl.shift = SHIFT_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= 7'd1;
      wp         <= '0;
      fill       <= '0;
      settle     <= 1'b1;
      byp_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      settle    <= setup.valid && setup.ready;
      byp_valid <= acc && (rd_addr == cur);
      if (setup.valid && setup.ready) begin
        window_len <= setup.window_len;
      end
      if (acc) begin
        wp        <= wp_next;
        fill      <= fill_next;
        out_valid <= emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (acc) begin
      byp_data <= x;
    end
    if (acc && emit) begin
      out_data <= $signed(front[SW-1:0]);
    end
  end

endmodule

// ===== hw/rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read (old data on collision).
module swm_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/swm_cell.sv =====
// One deque cell: holds a candidate, trims against the new sample, shifts toward the front.
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic                           left_kept,
  input  logic [SAMPLE_WIDTH:0]          near_post,  // post of the cell one behind
  input  logic [SAMPLE_WIDTH:0]          far_post,   // post of the cell two behind
  output logic                           kept,
  output logic [SAMPLE_WIDTH:0]          post        // {valid, value} after trim and append
);

  logic                           valid;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic [SAMPLE_WIDTH:0]          take;

  // Entry survives when it is not cleared and not smaller than the new sample.
  assign kept = valid && !ctl.first && !(value < x);

  always_comb begin
    if (kept) begin
      post = {1'b1, value};
    end else if (left_kept) begin
      post = {1'b1, x};
    end else begin
      post = {1'b0, x};
    end
  end

  always_comb begin
    case (ctl.shift)
      SHIFT_NONE: take = post;
      SHIFT_ONE:  take = near_post;
      SHIFT_TWO:  take = far_post;
      default:    take = post;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.update) begin
      valid <= take[SAMPLE_WIDTH];
    end
    if (ctl.update) begin
      value <= take[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ===== sim/sliding_window_maximum_top_tb.sv =====
// Self-checking testbench for the sliding window maximum filter: directed rows, then random phases.
module sliding_window_maximum_top_tb;

  localparam int WIN_DEPTH     = 64;
  localparam int SW            = 16;
  localparam int SETTLE_CYCLES = 8;       // margin for an item still in flight with no result
  localparam int LONG_HOLD     = 300;     // receiver hold-off that backs up the feed channel
  localparam int ITEM_GOAL     = 1070;    // directed rows plus about 1050 random items
  localparam int CALM_AT       = 920;     // from here on neither side idles
  localparam int RUN_LIMIT     = 5000000; // time units, several times the slowest clean run

  typedef logic signed [SW-1:0] sample_t;

  typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_t;

  // Sample shapes for the random phases.
  typedef enum logic [1:0] {STYLE_WIDE, STYLE_NARROW, STYLE_WALK, STYLE_EDGE} style_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [6:0] len;
    sample_t    sample;
    logic       first;
    logic       known;      // known_max is typed in; otherwise the predictor decides
    sample_t    known_max;
  } row_t;

  // Directed rows. Window length starts at its reset value of 1, so the first items
  // echo themselves; then a zero length (acts as 1), a short window that fills up,
  // a length above capacity, and a length cut mid-sequence that leaves stale candidates.
  row_t plan [0:23] = '{
    '{ROW_ITEM,  7'd0,   16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF},
    '{ROW_ITEM,  7'd0,   16'sh8000, 1'b0, 1'b1, 16'sh8000},
    '{ROW_ITEM,  7'd0,   16'sh0000, 1'b0, 1'b1, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'shFFFF, 1'b0, 1'b1, 16'shFFFF},
    '{ROW_ITEM,  7'd0,   16'sh5555, 1'b0, 1'b1, 16'sh5555},
    '{ROW_ITEM,  7'd0,   16'shAAAA, 1'b0, 1'b1, 16'shAAAA},
    '{ROW_SETUP, 7'd0,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0064, 1'b1, 1'b1, 16'sh0064},
    '{ROW_ITEM,  7'd0,   16'shFFFB, 1'b0, 1'b1, 16'shFFFB},
    '{ROW_SETUP, 7'd3,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh000A, 1'b1, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh001E, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0014, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0005, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0001, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_SETUP, 7'd127, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'shFFF9, 1'b1, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0008, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0008, 1'b0, 1'b0, 16'sh0000},
    '{ROW_SETUP, 7'd2,   16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'shFFFF, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'shFFFE, 1'b0, 1'b0, 16'sh0000},
    '{ROW_ITEM,  7'd0,   16'sh0003, 1'b0, 1'b0, 16'sh0000}
  };

  logic clk;
  logic rst;

  swm_in_if #(.SAMPLE_WIDTH(SW)) feed_if ();
  swm_out_if #(.SAMPLE_WIDTH(SW)) result_if ();
  swm_cfg_if setup_if ();

  sliding_window_maximum_top #(
    .WINDOW_MAX  (WIN_DEPTH),
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed_if),
    .result(result_if),
    .setup (setup_if)
  );

  // Predictor state: window length register, sample ring, candidate deque.
  logic [6:0] len_reg   = 7'd1;
  sample_t    hist [WIN_DEPTH];
  sample_t    cand [WIN_DEPTH];
  int         cand_cnt  = 0;
  int         cand_head = 0;
  int         filled    = 0;
  int         wr_ptr    = 0;

  sample_t    pending_max [$];   // window maxima still owed by the block, oldest first
  int         mismatches  = 0;
  int         items_sent  = 0;
  bit         calm        = 1'b0;
  bit         feed_gaps   = 1'b1;
  bit         hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("sliding_window_maximum_top: mismatch");
    $finish;
  end

  // Zero length behaves as 1, anything past capacity as the full ring.
  function automatic int clamp_len(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (int'(v) > WIN_DEPTH) return WIN_DEPTH;
    return int'(v);
  endfunction

  // One accepted sample through the window; returns 1 when a maximum is due.
  function automatic bit advance_window(input sample_t x, input logic start,
                                        output sample_t y);
    int span;
    int cur;
    int oldest;
    span = clamp_len(len_reg);
    y    = '0;
    if (start) begin
      cand_cnt  = 0;
      cand_head = 0;
      filled    = 0;
      wr_ptr    = 0;
    end
    // trim smaller candidates off the back (signed compare)
    while (cand_cnt > 0 && cand[(cand_head + cand_cnt - 1) % WIN_DEPTH] < x)
      cand_cnt--;
    // only reachable after a length change left stale candidates
    if (cand_cnt >= WIN_DEPTH) begin
      cand_head = (cand_head + 1) % WIN_DEPTH;
      cand_cnt--;
    end
    cand[(cand_head + cand_cnt) % WIN_DEPTH] = x;
    cand_cnt++;
    cur       = wr_ptr;
    hist[cur] = x;
    wr_ptr    = (cur + 1) % WIN_DEPTH;
    if (filled < WIN_DEPTH) filled++;
    if (filled < span) return 1'b0;
    y      = cand[cand_head];
    oldest = (cur + WIN_DEPTH - (span - 1)) % WIN_DEPTH;
    if (y == hist[oldest]) begin
      cand_head = (cand_head + 1) % WIN_DEPTH;
      cand_cnt--;
    end
    return 1'b1;
  endfunction

  function automatic sample_t next_sample(input sample_t prev, input style_t style);
    case (style)
      STYLE_NARROW: return sample_t'(int'($urandom_range(0, 4)) - 2);
      STYLE_WALK:   return prev + sample_t'(int'($urandom_range(0, 64)) - 32);
      STYLE_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return sample_t'($urandom_range(0, 65535));
          default: return prev;
        endcase
      end
      default:      return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Drop feed valid, wait for every owed maximum, then a few quiet cycles.
  task automatic settle_block();
    feed_if.valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [6:0] v);
    settle_block();
    setup_if.valid      <= 1'b1;
    setup_if.window_len <= v;
    do @(posedge clk); while (!setup_if.ready);
    setup_if.valid <= 1'b0;
    len_reg = v;
  endtask

  // Offer one item; valid stays high afterwards so back-to-back items need no re-raise.
  task automatic send_item(input sample_t s, input logic start, input logic known,
                           input sample_t known_max);
    sample_t predicted;
    if (feed_gaps && !calm && $urandom_range(0, 5) == 0) begin
      feed_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    feed_if.valid  <= 1'b1;
    feed_if.sample <= s;
    feed_if.first  <= start;
    do @(posedge clk); while (!feed_if.ready);
    if (advance_window(s, start, predicted))
      pending_max = {pending_max, (known ? known_max : predicted)};
    items_sent++;
  endtask

  // Result side: random stall bursts, one long hold-off on request, none once calm.
  initial begin
    result_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare each accepted maximum with the oldest one owed.
  always @(posedge clk) begin : check_results
    sample_t want;
    if (rst === 1'b0 && result_if.valid && result_if.ready) begin
      if (pending_max.size() == 0) begin
        $error("window_max: nothing expected, got %0d", result_if.window_max);
        mismatches++;
      end else begin
        want = pending_max[0];
        pending_max.delete(0);
        if (result_if.window_max !== want) begin
          $error("window_max: expected %0d, got %0d", want, result_if.window_max);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int         phase;
    int         count;
    int         pick;
    logic [6:0] len;
    bit         fresh;
    style_t     style;
    sample_t    s;

    rst                 <= 1'b1;
    feed_if.valid       <= 1'b0;
    feed_if.sample      <= '0;
    feed_if.first       <= 1'b0;
    setup_if.valid      <= 1'b0;
    setup_if.window_len <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(plan); r++) begin
      if (plan[r].kind == ROW_SETUP)
        write_len(plan[r].len);
      else
        send_item(plan[r].sample, plan[r].first, plan[r].known, plan[r].known_max);
    end

    phase = 0;
    s     = '0;
    while (items_sent < ITEM_GOAL) begin
      calm      = (items_sent >= CALM_AT);
      feed_gaps = ($urandom_range(0, 2) != 0);
      if (phase == 0) begin
        // Long strictly falling run in a full-size window, then the window shrinks
        // mid-sequence: the stale front never leaves, so the deque runs full.
        s = 16'sd30000;
        write_len(7'd64);
        for (int i = 0; i < 130; i++) begin
          if (i == 40) write_len(7'($urandom_range(1, 6)));
          send_item(s, i == 0, 1'b0, '0);
          s = s - sample_t'($urandom_range(1, 200));
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = 7'd0;
        else if (pick == 1) len = 7'd127;
        else if (pick == 2) len = 7'($urandom_range(65, 126));
        else if (pick == 3) len = 7'd64;
        else if (pick < 7)  len = 7'($urandom_range(17, 63));
        else                len = 7'($urandom_range(1, 16));
        // mostly fresh sequences; the rest carry on, possibly under a new length
        fresh = (phase == 3) || ($urandom_range(0, 4) != 0);
        if (phase == 3) begin
          // back-pressure phase: steady feed while the receiver holds off
          len       = 7'd2;
          feed_gaps = 1'b0;
        end
        if (phase == 3 || $urandom_range(0, 2) != 0) write_len(len);
        if (phase == 3) hold_req = 1'b1;
        count = (phase == 3) ? 60 : $urandom_range(1, 3 * clamp_len(len_reg));
        style = style_t'($urandom_range(0, 3));
        for (int i = 0; i < count; i++) begin
          s = next_sample(s, style);
          send_item(s, (i == 0 && fresh) || $urandom_range(0, 39) == 0, 1'b0, '0);
        end
      end
      phase++;
    end

    settle_block();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("sliding_window_maximum_top: match");
    else
      $display("sliding_window_maximum_top: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_in_if.sv
hw/rtl/swm_out_if.sv
hw/rtl/swm_cfg_if.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_maximum_top.sv
sim/sliding_window_maximum_top_tb.sv
